// File: rtl/ifla_pkg.sv
// ----------------------------------------------------------------------------
// ifla_pkg
// Shared constants, operation codes and controller/datapath bundles for the
// index free-list allocator.
// ----------------------------------------------------------------------------
package ifla_pkg;

  localparam int ENTRIES = 256;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int HOP_W   = ADDR_W + 1;
  localparam int CFG_W   = 9;
  localparam int OP_W    = 3;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 8;

  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic sweep_start;
    logic sweep_write;
    logic sweep_cfg;
    logic alloc_issue;
    logic alloc_pop;
    logic set_exhausted;
    logic set_rejected;
    logic free_push;
    logic walk_start;
    logic walk_issue;
    logic walk_step;
    logic walk_hit;
    logic publish;
  } ifla_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_bad;
    logic            head_zero;
    logic            walk_end;
    logic            walk_hit;
    logic            sweep_last;
    logic            out_free;
  } ifla_status_t;

endpackage

// File: rtl/ifla_in_if.sv
// ----------------------------------------------------------------------------
// ifla_in_if
// Request channel: operation code and slot index with valid/ready.
// ----------------------------------------------------------------------------
interface ifla_in_if import ifla_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  item_index;

  modport source (output valid, output operation, output item_index, input ready);
  modport sink   (input valid, input operation, input item_index, output ready);

endinterface

// File: rtl/ifla_out_if.sv
// ----------------------------------------------------------------------------
// ifla_out_if
// Response channel: one result per request with valid/ready.
// ----------------------------------------------------------------------------
interface ifla_out_if import ifla_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  granted_index;
  logic              exhausted;
  logic              alive;
  logic [CNT_W-1:0]  used_entries;
  logic              rejected;

  modport source (output valid, output granted_index, output exhausted, output alive,
                  output used_entries, output rejected, input ready);
  modport sink   (input valid, input granted_index, input exhausted, input alive,
                  input used_entries, input rejected, output ready);

endinterface

// File: rtl/index_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// index_free_list_allocator_top
// Allocator of slot indices kept on a singly linked free chain in a RAM.
// ----------------------------------------------------------------------------
// From accept to result: free, rejected and empty allocate go straight from
// decode to the result; allocate adds one dependent link RAM read, query and
// count one link RAM read per chain hop, clear a sweep over the effective
// table size n. One request is in flight at a time, so a new request is
// accepted only once the previous one is published; the result register lets
// it be accepted while the previous result waits.
// Reset is synchronous; afterwards a sweep over link RAM entries 1 to 255
// builds the full chain in the link RAM and no request is accepted until it ends.
module index_free_list_allocator_top import ifla_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  ifla_in_if.sink          in_ch,
  ifla_out_if.source       out_ch
);

  ifla_cmd_t    cmd;
  ifla_status_t status;

  ifla_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .status  (status),
    .cmd     (cmd)
  );

  ifla_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_operation     (in_ch.operation),
    .in_item_index    (in_ch.item_index),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_granted_index(out_ch.granted_index),
    .out_exhausted    (out_ch.exhausted),
    .out_alive        (out_ch.alive),
    .out_used_entries (out_ch.used_entries),
    .out_rejected     (out_ch.rejected)
  );

endmodule

// File: rtl/ifla_ram.sv
// ----------------------------------------------------------------------------
// ifla_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ifla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ifla_ctrl.sv
// ----------------------------------------------------------------------------
// ifla_ctrl
// Sequencer for the allocator: decodes each request and steps the datapath
// through sweeps, pops, pushes and chain walks.
// ----------------------------------------------------------------------------
module ifla_ctrl import ifla_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ifla_status_t status,
  output ifla_cmd_t    cmd
);

  localparam logic [2:0] S_RST_SWEEP  = 3'd0;
  localparam logic [2:0] S_IDLE       = 3'd1;
  localparam logic [2:0] S_EXEC       = 3'd2;
  localparam logic [2:0] S_CLR_SWEEP  = 3'd3;
  localparam logic [2:0] S_ALLOC_WAIT = 3'd4;
  localparam logic [2:0] S_WALK       = 3'd5;
  localparam logic [2:0] S_WALK_WAIT  = 3'd6;
  localparam logic [2:0] S_FIN        = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_RST_SWEEP: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FIN;
        case (status.op)
          OP_CLEAR: begin
            cmd.sweep_start = 1'b1;
            state_next      = S_CLR_SWEEP;
          end
          OP_ALLOC: begin
            if (status.head_zero) begin
              cmd.set_exhausted = 1'b1;
            end else begin
              cmd.alloc_issue = 1'b1;
              state_next      = S_ALLOC_WAIT;
            end
          end
          OP_FREE: begin
            if (status.idx_bad) begin
              cmd.set_rejected = 1'b1;
            end else begin
              cmd.free_push = 1'b1;
            end
          end
          OP_QUERY: begin
            if (status.idx_bad) begin
              cmd.set_rejected = 1'b1;
            end else begin
              cmd.walk_start = 1'b1;
              state_next     = S_WALK;
            end
          end
          OP_COUNT: begin
            cmd.walk_start = 1'b1;
            state_next     = S_WALK;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_CLR_SWEEP: begin
        cmd.sweep_write = 1'b1;
        cmd.sweep_cfg   = 1'b1;
        if (status.sweep_last) begin
          state_next = S_FIN;
        end
      end
      S_ALLOC_WAIT: begin
        cmd.alloc_pop = 1'b1;
        state_next    = S_FIN;
      end
      S_WALK: begin
        if (status.walk_end) begin
          state_next = S_FIN;
        end else if (status.op == OP_QUERY && status.walk_hit) begin
          cmd.walk_hit = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.walk_issue = 1'b1;
          state_next     = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        cmd.walk_step = 1'b1;
        state_next    = S_WALK;
      end
      S_FIN: begin
        // Hold the result until the output register is free.
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ifla_datapath.sv
// ----------------------------------------------------------------------------
// ifla_datapath
// Link memory, chain head, walk and sweep counters, size register and the
// result and output registers.
// ----------------------------------------------------------------------------
module ifla_datapath import ifla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [IDX_W-1:0]  in_item_index,
  input  ifla_cmd_t         cmd,
  output ifla_status_t      status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_granted_index,
  output logic              out_exhausted,
  output logic              out_alive,
  output logic [CNT_W-1:0]  out_used_entries,
  output logic              out_rejected
);

  logic [CFG_W-1:0]  entries_in_use;
  logic [CFG_W-1:0]  n_eff;
  logic [ADDR_W-1:0] n_minus1;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] cur;
  logic [HOP_W-1:0]  hops;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] sweep_limit;
  logic [ADDR_W-1:0] sweep_data;
  logic [IDX_W-1:0]  res_granted;
  logic              res_exhausted;
  logic              res_alive;
  logic              res_rejected;
  logic [CNT_W+1:0]  used_diff;
  logic [CNT_W-1:0]  used_val;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;

  // The register value is held to the range the table supports.
  always_comb begin
    if (entries_in_use < CFG_W'(2)) begin
      n_eff = CFG_W'(2);
    end else if (entries_in_use > CFG_W'(ENTRIES)) begin
      n_eff = CFG_W'(ENTRIES);
    end else begin
      n_eff = entries_in_use;
    end
  end

  assign n_minus1    = ADDR_W'(n_eff - CFG_W'(1));
  assign sweep_limit = cmd.sweep_cfg ? n_minus1 : ADDR_W'(ENTRIES - 1);
  assign sweep_data  = (sweep_addr == sweep_limit) ? '0 : sweep_addr + ADDR_W'(1);

  always_comb begin
    if (cmd.sweep_write) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = sweep_data;
    end else begin
      ram_we    = cmd.free_push;
      ram_waddr = idx;
      ram_wdata = head;
    end
  end

  assign ram_raddr = cmd.walk_issue ? cur : head;

  ifla_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(ENTRIES)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Count result: table slots less one for entry 0, minus free chain length, held to [0, 255].
  assign used_diff = {1'b0, n_eff} - {1'b0, hops} - (CNT_W + 2)'(1);
  always_comb begin
    if ({1'b0, n_eff} <= {1'b0, hops} + (CFG_W + 1)'(1)) begin
      used_val = '0;
    end else if (used_diff > (CNT_W + 2)'(255)) begin
      used_val = '1;
    end else begin
      used_val = used_diff[CNT_W-1:0];
    end
  end

  // Entry 0 of the table lives in the head register; the RAM keeps the rest.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CFG_W'(ENTRIES);
      head           <= ADDR_W'(1);
      sweep_addr     <= ADDR_W'(1);
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        entries_in_use <= cfg_data;
      end
      if (cmd.sweep_start) begin
        head       <= ADDR_W'(1);
        sweep_addr <= ADDR_W'(1);
      end else if (cmd.sweep_write) begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
      end
      if (cmd.free_push) begin
        head <= idx;
      end else if (cmd.alloc_pop) begin
        head <= ram_rdata;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op            <= in_operation;
      idx           <= in_item_index;
      res_granted   <= '0;
      res_exhausted <= 1'b0;
      res_alive     <= 1'b0;
      res_rejected  <= 1'b0;
    end
    if (cmd.alloc_issue) begin
      res_granted <= head;
    end
    if (cmd.set_exhausted) begin
      res_exhausted <= 1'b1;
    end
    if (cmd.set_rejected) begin
      res_rejected <= 1'b1;
    end
    if (cmd.walk_start) begin
      cur       <= head;
      hops      <= '0;
      res_alive <= (op == OP_QUERY);
    end else if (cmd.walk_step) begin
      cur  <= ram_rdata;
      hops <= hops + HOP_W'(1);
    end
    if (cmd.walk_hit) begin
      res_alive <= 1'b0;
    end
    if (cmd.publish) begin
      out_granted_index <= res_granted;
      out_exhausted     <= res_exhausted;
      out_alive         <= res_alive;
      out_used_entries  <= (op == OP_COUNT) ? used_val : '0;
      out_rejected      <= res_rejected;
    end
  end

  assign status.op         = op;
  assign status.idx_bad    = (idx == '0) || ({1'b0, idx} >= n_eff);
  assign status.head_zero  = (head == '0);
  assign status.walk_end   = (cur == '0) || (hops == HOP_W'(ENTRIES));
  assign status.walk_hit   = (cur == idx);
  assign status.sweep_last = (sweep_addr == sweep_limit);
  assign status.out_free   = !out_valid || out_ready;

endmodule
